### hw/rtl/rwp_pkg.sv
`timescale 1ns / 1ps

package rwp_pkg;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BAD_HEADER  = 3'd1;
  localparam logic [2:0] ST_TRUNCATED   = 3'd2;
  localparam logic [2:0] ST_SHORT_FMT   = 3'd3;
  localparam logic [2:0] ST_MISSING     = 3'd4;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd5;
  localparam logic [2:0] ST_ODD_DATA    = 3'd6;

  localparam logic [1:0] CFG_FORMAT   = 2'd0;
  localparam logic [1:0] CFG_CHANNELS = 2'd1;
  localparam logic [1:0] CFG_RATE     = 2'd2;
  localparam logic [1:0] CFG_BITS     = 2'd3;

  localparam int OUT_W  = 152;
  localparam int HDR_LEN = 12;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [31:0] pos;
    logic        magic_bad;
    logic        hdr_done;
  } q_item_t;

  function automatic logic [7:0] magic_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'h52;
      4'd1:    b = 8'h49;
      4'd2:    b = 8'h46;
      4'd3:    b = 8'h46;
      4'd8:    b = 8'h57;
      4'd9:    b = 8'h41;
      4'd10:   b = 8'h56;
      4'd11:   b = 8'h45;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

### hw/rtl/rwp_front.sv
`timescale 1ns / 1ps

module rwp_front
  import rwp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // file_byte[7:0]
  input  logic       in_tlast,
  input  logic       q_full,
  output logic       q_push,
  output q_item_t    q_item
);

  logic [31:0] pos_r;
  logic [31:0] pos_nxt;
  logic        in_hdr;
  logic        magic_slot;

  assign in_tready  = !q_full;
  assign q_push     = in_tvalid && in_tready;
  assign in_hdr     = pos_r < 32'(HDR_LEN);
  assign magic_slot = (pos_r < 32'd4) || (pos_r >= 32'd8);

  always_comb begin
    q_item.data      = in_tdata;
    q_item.last      = in_tlast;
    q_item.pos       = pos_r;
    q_item.magic_bad = in_hdr && magic_slot && (in_tdata != magic_byte(pos_r[3:0]));
    q_item.hdr_done  = pos_r >= 32'(HDR_LEN - 1);
  end

  // count every byte; restart on the final one
  always_comb begin
    pos_nxt = pos_r;
    if (q_push) begin
      pos_nxt = in_tlast ? 32'd0 : pos_r + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 32'd0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

### hw/rtl/rwp_queue.sv
`timescale 1ns / 1ps

module rwp_queue
  import rwp_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  q_item_t push_item,
  output logic    full,
  input  logic    pop,
  output logic    valid,
  output q_item_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  q_item_t         mem_r [DEPTH];
  logic [PW-1:0]   wr_r;
  logic [PW-1:0]   wr_nxt;
  logic [PW-1:0]   rd_r;
  logic [PW-1:0]   rd_nxt;
  logic [CW-1:0]   cnt_r;
  logic [CW-1:0]   cnt_nxt;

  assign full  = cnt_r == CW'(DEPTH);
  assign valid = cnt_r != '0;
  assign head  = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + PW'(1);
    end
    if (pop) begin
      rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### hw/rtl/rwp_back.sv
`timescale 1ns / 1ps

module rwp_back
  import rwp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  q_item_t          q_head,
  output logic             q_pop,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_addr,
  input  logic [31:0]      cfg_wdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata
);

  localparam logic [1:0] PH_FILE_HDR  = 2'd0;
  localparam logic [1:0] PH_CHUNK_HDR = 2'd1;
  localparam logic [1:0] PH_PAYLOAD   = 2'd2;
  localparam logic [1:0] PH_PAD       = 2'd3;

  localparam logic [1:0] KIND_OTHER = 2'd0;
  localparam logic [1:0] KIND_FMT   = 2'd1;
  localparam logic [1:0] KIND_DATA  = 2'd2;

  localparam logic [31:0] ID_FMT  = 32'h20746D66;
  localparam logic [31:0] ID_DATA = 32'h61746164;
  localparam logic [4:0]  IDX_SAT = 5'd16;

  logic [15:0] exp_format_r, exp_channels_r, exp_bits_r;
  logic [31:0] exp_rate_r;

  logic [1:0]  phase_r, phase_nxt;
  logic [31:0] fs_r, fs_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [4:0]  pidx_r, pidx_nxt;
  logic        pad_r, pad_nxt;
  logic        sfp_r, sfp_nxt;
  logic        seen_fmt_r, seen_fmt_nxt;
  logic        seen_data_r, seen_data_nxt;
  logic [2:0]  err_r, err_nxt;
  logic [31:0] off_r, off_nxt;
  logic [31:0] size_r, size_nxt;
  logic [15:0] fmt_r, fmt_nxt;
  logic [15:0] chan_r, chan_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [15:0] bits_r, bits_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;
  logic             out_free;
  logic [2:0]       status;

  assign out_free   = !out_valid_r || out_tready;
  assign q_pop      = q_valid && (!q_head.last || out_free);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    phase_nxt     = phase_r;
    fs_nxt        = fs_r;
    kind_nxt      = kind_r;
    rem_nxt       = rem_r;
    pidx_nxt      = pidx_r;
    pad_nxt       = pad_r;
    sfp_nxt       = sfp_r;
    seen_fmt_nxt  = seen_fmt_r;
    seen_data_nxt = seen_data_r;
    err_nxt       = err_r;
    off_nxt       = off_r;
    size_nxt      = size_r;
    fmt_nxt       = fmt_r;
    chan_nxt      = chan_r;
    rate_nxt      = rate_r;
    bits_nxt      = bits_r;
    status        = ST_OK;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;

    if (q_pop && err_r == ST_OK) begin
      unique case (phase_r)
        PH_FILE_HDR: begin
          if (q_head.magic_bad) begin
            err_nxt = ST_BAD_HEADER;
          end else if (q_head.hdr_done) begin
            phase_nxt = PH_CHUNK_HDR;
            pidx_nxt  = '0;
          end else if (q_head.last) begin
            err_nxt = ST_BAD_HEADER;
          end
        end
        PH_CHUNK_HDR: begin
          fs_nxt   = {q_head.data, fs_r[31:8]};
          pidx_nxt = pidx_r + 5'd1;
          if (pidx_nxt == 5'd4) begin
            if (fs_nxt == ID_FMT) begin
              kind_nxt = KIND_FMT;
            end else if (fs_nxt == ID_DATA) begin
              kind_nxt = KIND_DATA;
            end else begin
              kind_nxt = KIND_OTHER;
            end
          end else if (pidx_nxt >= 5'd8) begin
            rem_nxt = fs_nxt;
            pad_nxt = fs_nxt[0];
            sfp_nxt = 1'b0;
            if (kind_r == KIND_FMT) begin
              if (fs_nxt < 32'd16) begin
                sfp_nxt = 1'b1;
              end else begin
                seen_fmt_nxt = 1'b1;
              end
            end else if (kind_r == KIND_DATA) begin
              seen_data_nxt = 1'b1;
              off_nxt       = q_head.pos + 32'd1;
              size_nxt      = fs_nxt;
            end
            pidx_nxt = '0;
            if (fs_nxt == 32'd0) begin
              if (sfp_nxt) begin
                err_nxt = ST_SHORT_FMT;
              end
              sfp_nxt   = 1'b0;
              phase_nxt = pad_nxt ? PH_PAD : PH_CHUNK_HDR;
            end else begin
              phase_nxt = PH_PAYLOAD;
              if (q_head.last) begin
                err_nxt = ST_TRUNCATED;
              end
            end
          end
        end
        PH_PAYLOAD: begin
          if (kind_r == KIND_FMT && !sfp_r) begin
            case (pidx_r)
              5'd0:    fmt_nxt[7:0]    = q_head.data;
              5'd1:    fmt_nxt[15:8]   = q_head.data;
              5'd2:    chan_nxt[7:0]   = q_head.data;
              5'd3:    chan_nxt[15:8]  = q_head.data;
              5'd4:    rate_nxt[7:0]   = q_head.data;
              5'd5:    rate_nxt[15:8]  = q_head.data;
              5'd6:    rate_nxt[23:16] = q_head.data;
              5'd7:    rate_nxt[31:24] = q_head.data;
              5'd14:   bits_nxt[7:0]   = q_head.data;
              5'd15:   bits_nxt[15:8]  = q_head.data;
              default: ;
            endcase
          end
          if (pidx_r != IDX_SAT) begin
            pidx_nxt = pidx_r + 5'd1;
          end
          rem_nxt = rem_r - 32'd1;
          if (rem_nxt == 32'd0) begin
            if (sfp_r) begin
              err_nxt = ST_SHORT_FMT;
            end
            sfp_nxt   = 1'b0;
            pidx_nxt  = '0;
            phase_nxt = pad_r ? PH_PAD : PH_CHUNK_HDR;
          end else if (q_head.last) begin
            err_nxt = ST_TRUNCATED;
          end
        end
        default: begin
          pad_nxt   = 1'b0;
          pidx_nxt  = '0;
          phase_nxt = PH_CHUNK_HDR;
        end
      endcase
    end

    if (q_pop && q_head.last) begin
      status = err_nxt;
      if (status == ST_OK) begin
        if (!seen_fmt_nxt || !seen_data_nxt) begin
          status = ST_MISSING;
        end else if (fmt_nxt != exp_format_r || chan_nxt != exp_channels_r ||
                     rate_nxt != exp_rate_r || bits_nxt != exp_bits_r) begin
          status = ST_UNSUPPORTED;
        end else if (size_nxt[0]) begin
          status = ST_ODD_DATA;
        end
      end
      out_valid_nxt = 1'b1;
      out_data_nxt  = {5'd0, bits_nxt, rate_nxt, chan_nxt, fmt_nxt,
                       size_nxt, off_nxt, status};
      phase_nxt     = PH_FILE_HDR;
      fs_nxt        = '0;
      kind_nxt      = KIND_OTHER;
      rem_nxt       = '0;
      pidx_nxt      = '0;
      pad_nxt       = 1'b0;
      sfp_nxt       = 1'b0;
      seen_fmt_nxt  = 1'b0;
      seen_data_nxt = 1'b0;
      err_nxt       = ST_OK;
      off_nxt       = '0;
      size_nxt      = '0;
      fmt_nxt       = '0;
      chan_nxt      = '0;
      rate_nxt      = '0;
      bits_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_format_r   <= 16'd1;
      exp_channels_r <= 16'd1;
      exp_rate_r     <= 32'd16000;
      exp_bits_r     <= 16'd16;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_FORMAT:   exp_format_r   <= cfg_wdata[15:0];
        CFG_CHANNELS: exp_channels_r <= cfg_wdata[15:0];
        CFG_RATE:     exp_rate_r     <= cfg_wdata;
        CFG_BITS:     exp_bits_r     <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_FILE_HDR;
      fs_r        <= '0;
      kind_r      <= KIND_OTHER;
      rem_r       <= '0;
      pidx_r      <= '0;
      pad_r       <= 1'b0;
      sfp_r       <= 1'b0;
      seen_fmt_r  <= 1'b0;
      seen_data_r <= 1'b0;
      err_r       <= ST_OK;
      off_r       <= '0;
      size_r      <= '0;
      fmt_r       <= '0;
      chan_r      <= '0;
      rate_r      <= '0;
      bits_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      fs_r        <= fs_nxt;
      kind_r      <= kind_nxt;
      rem_r       <= rem_nxt;
      pidx_r      <= pidx_nxt;
      pad_r       <= pad_nxt;
      sfp_r       <= sfp_nxt;
      seen_fmt_r  <= seen_fmt_nxt;
      seen_data_r <= seen_data_nxt;
      err_r       <= err_nxt;
      off_r       <= off_nxt;
      size_r      <= size_nxt;
      fmt_r       <= fmt_nxt;
      chan_r      <= chan_nxt;
      rate_r      <= rate_nxt;
      bits_r      <= bits_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_err_not_in_payload: assert property (@(posedge clk) disable iff (!rst_n)
    err_r != ST_OK |-> phase_r != PH_PAYLOAD)
    else $error("error latched while in payload phase");

  a_no_pad_in_header: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_CHUNK_HDR || phase_r == PH_FILE_HDR) |-> !pad_r)
    else $error("pad pending outside payload");

  a_hdr_index: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_CHUNK_HDR |-> pidx_r < 5'd8)
    else $error("chunk header index overrun");

  a_result_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_head.last) |-> out_free)
    else $error("final byte taken while result register busy");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_head.last) |=> (phase_r == PH_FILE_HDR && err_r == ST_OK && out_valid_r))
    else $error("state not cleared after final byte");

endmodule

### hw/rtl/riff_wav_header_parser.sv
`timescale 1ns / 1ps
// The result appears on out_tvalid after the final byte has passed the byte queue
// and the result register. Throughput: one byte per clock, set by the single-byte
// parse step of the back end; a final byte waits while the result register is busy.
// Reset (rst_n low at a clock edge) restores the expected fmt values and clears
// all parse state, the byte queue and the result register.

module riff_wav_header_parser
  import rwp_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,   // file_byte[7:0]
  input  logic             in_tlast,
  output logic             out_tvalid,
  input  logic             out_tready,
  // status[2:0], data_offset[34:3], data_bytes[66:35], format_code[82:67],
  // channel_count[98:83], rate_hz[130:99], sample_bits[146:131], zero pad
  output logic [OUT_W-1:0] out_tdata,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_addr,
  input  logic [31:0]      cfg_wdata
);

  logic    q_full;
  logic    q_push;
  q_item_t q_in;
  logic    q_pop;
  logic    q_valid;
  q_item_t q_head;

  rwp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_in)
  );

  rwp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  rwp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

### sim/wav_summary_checker.sv
`timescale 1ns / 1ps

module wav_summary_checker
  import rwp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [7:0]       in_tdata,   // file_byte[7:0]
  input  logic             in_tlast,
  input  logic             out_tvalid,
  input  logic             out_tready,
  // status[2:0], data_offset[34:3], data_bytes[66:35], format_code[82:67],
  // channel_count[98:83], rate_hz[130:99], sample_bits[146:131], zero pad
  input  logic [OUT_W-1:0] out_tdata,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_addr,
  input  logic [31:0]      cfg_wdata,
  output int               fails,
  output int               outstanding
);

  typedef enum logic [1:0] {HDR_STAGE, CHUNK_HEAD, BODY, PAD_SKIP} stage_t;
  typedef enum logic [1:0] {OTHER_CHUNK, FMT_CHUNK, DATA_CHUNK} chunk_t;

  typedef struct packed {
    logic [15:0] bits;
    logic [31:0] rate;
    logic [15:0] chans;
    logic [15:0] fmt;
    logic [31:0] size;
    logic [31:0] offset;
    logic [2:0]  status;
  } wav_summary_t;

  localparam logic [95:0] FILE_MAGIC = 96'h45564157_00000000_46464952;
  localparam logic [31:0] FMT_ID     = 32'h20746D66;
  localparam logic [31:0] DATA_ID    = 32'h61746164;

  logic [15:0]  want_format;
  logic [15:0]  want_channels;
  logic [31:0]  want_rate;
  logic [15:0]  want_bits;

  logic [31:0]  pos_cnt;
  stage_t       stage;
  logic [31:0]  shreg;
  chunk_t       kind;
  logic [31:0]  left;
  logic [31:0]  idx;
  logic         pad_due;
  logic         short_due;
  logic         got_fmt;
  logic         got_data;
  logic [2:0]   err;
  wav_summary_t kept;

  wav_summary_t summary_q[$];
  int           bad_cnt = 0;

  task automatic clear_parse();
    pos_cnt   = '0;
    stage     = HDR_STAGE;
    shreg     = '0;
    kind      = OTHER_CHUNK;
    left      = '0;
    idx       = '0;
    pad_due   = 1'b0;
    short_due = 1'b0;
    got_fmt   = 1'b0;
    got_data  = 1'b0;
    err       = ST_OK;
    kept      = '0;
  endtask

  task automatic close_chunk();
    if (short_due) begin
      err = ST_SHORT_FMT;
    end
    short_due = 1'b0;
    idx       = '0;
    stage     = pad_due ? PAD_SKIP : CHUNK_HEAD;
  endtask

  task automatic grab_fmt_byte(input logic [7:0] b);
    case (idx)
      32'd0:  kept.fmt[7:0]   = b;
      32'd1:  kept.fmt[15:8]  = b;
      32'd2:  kept.chans[7:0]  = b;
      32'd3:  kept.chans[15:8] = b;
      32'd4, 32'd5, 32'd6, 32'd7: kept.rate[{idx[1:0], 3'b000} +: 8] = b;
      32'd14: kept.bits[7:0]  = b;
      32'd15: kept.bits[15:8] = b;
      default: ;
    endcase
  endtask

  task automatic walk_byte(input logic [7:0] b, input logic fin);
    logic [31:0] pos;
    pos = pos_cnt;
    case (stage)
      HDR_STAGE: begin
        if (pos < 12 && (pos < 4 || pos >= 8) && b != FILE_MAGIC[{pos[3:0], 3'b000} +: 8]) begin
          err = ST_BAD_HEADER;
        end else if (pos >= 11) begin
          stage = CHUNK_HEAD;
          idx   = '0;
        end else if (fin) begin
          err = ST_BAD_HEADER;
        end
      end
      CHUNK_HEAD: begin
        shreg = {b, shreg[31:8]};
        idx   = idx + 1;
        if (idx == 4) begin
          if (shreg == FMT_ID) kind = FMT_CHUNK;
          else if (shreg == DATA_ID) kind = DATA_CHUNK;
          else kind = OTHER_CHUNK;
        end else if (idx >= 8) begin
          left      = shreg;
          pad_due   = shreg[0];
          short_due = 1'b0;
          if (kind == FMT_CHUNK) begin
            if (shreg < 16) short_due = 1'b1;
            else got_fmt = 1'b1;
          end else if (kind == DATA_CHUNK) begin
            got_data    = 1'b1;
            kept.offset = pos + 1;
            kept.size   = shreg;
          end
          idx = '0;
          if (shreg == 0) begin
            close_chunk();
          end else begin
            stage = BODY;
            if (fin) err = ST_TRUNCATED;
          end
        end
      end
      BODY: begin
        if (kind == FMT_CHUNK && !short_due) grab_fmt_byte(b);
        idx  = idx + 1;
        left = left - 1;
        if (left == 0) begin
          close_chunk();
        end else if (fin) begin
          err = ST_TRUNCATED;
        end
      end
      default: begin
        pad_due = 1'b0;
        idx     = '0;
        stage   = CHUNK_HEAD;
      end
    endcase
  endtask

  task automatic take_item(input logic [7:0] b, input logic fin);
    logic [2:0] stat;
    if (err == ST_OK) walk_byte(b, fin);
    pos_cnt = pos_cnt + 1;
    if (fin) begin
      stat = err;
      if (stat == ST_OK) begin
        if (!got_fmt || !got_data) begin
          stat = ST_MISSING;
        end else if (kept.fmt != want_format || kept.chans != want_channels ||
                     kept.rate != want_rate || kept.bits != want_bits) begin
          stat = ST_UNSUPPORTED;
        end else if (kept.size[0]) begin
          stat = ST_ODD_DATA;
        end
      end
      kept.status = stat;
      summary_q = {summary_q, kept};
      clear_parse();
    end
  endtask

  task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      bad_cnt++;
      if (bad_cnt <= 10) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      end
    end
  endtask

  always @(posedge clk) begin : monitor
    wav_summary_t got;
    wav_summary_t want;
    if (!rst_n) begin
      want_format   = 16'd1;
      want_channels = 16'd1;
      want_rate     = 32'd16000;
      want_bits     = 16'd16;
      clear_parse();
      summary_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_FORMAT:   want_format   = cfg_wdata[15:0];
          CFG_CHANNELS: want_channels = cfg_wdata[15:0];
          CFG_RATE:     want_rate     = cfg_wdata;
          CFG_BITS:     want_bits     = cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[146:0];
        if (summary_q.size() == 0) begin
          bad_cnt++;
          if (bad_cnt <= 10) $display("%0t: result with none expected: %h", $time, got);
        end else begin
          want = summary_q.pop_front();
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("data_offset", want.offset, got.offset);
          check_field("data_bytes", want.size, got.size);
          check_field("format_code", 32'(want.fmt), 32'(got.fmt));
          check_field("channel_count", 32'(want.chans), 32'(got.chans));
          check_field("rate_hz", want.rate, got.rate);
          check_field("sample_bits", 32'(want.bits), 32'(got.bits));
        end
      end
      if (in_tvalid && in_tready) take_item(in_tdata, in_tlast);
    end
    fails       <= bad_cnt;
    outstanding <= summary_q.size();
  end

endmodule

### sim/tb_riff_wav_header_parser.sv
`timescale 1ns / 1ps

module tb_riff_wav_header_parser;
  import rwp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 1000;
  localparam int PHASE_BYTES = 190;
  localparam int PHASE_FILES = 3;

  localparam logic [31:0] RIFF_TAG = 32'h46464952;
  localparam logic [31:0] WAVE_TAG = 32'h45564157;
  localparam logic [31:0] FMT_TAG  = 32'h20746D66;
  localparam logic [31:0] DATA_TAG = 32'h61746164;
  localparam logic [31:0] LIST_TAG = 32'h5453494C;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic [7:0]       in_tdata   = 8'h00;
  logic             in_tlast   = 1'b0;
  logic             out_tready = 1'b0;
  logic             cfg_we     = 1'b0;
  logic [1:0]       cfg_addr   = CFG_FORMAT;
  logic [31:0]      cfg_wdata  = 32'h0;
  wire              in_tready;
  wire              out_tvalid;
  wire [OUT_W-1:0]  out_tdata;
  int               fails;
  int               outstanding;

  int               cycles     = 0;
  int               bytes_sent = 0;
  int               files_sent = 0;
  int               gap_odds   = 0;
  logic             calm       = 1'b0;
  logic             hold_req   = 1'b0;
  logic             hold_done  = 1'b0;
  logic             pad_at_end = 1'b0;
  logic [7:0]       wav_q[$];

  logic [15:0]      cur_format   = 16'd1;
  logic [15:0]      cur_channels = 16'd1;
  logic [31:0]      cur_rate     = 32'd16000;
  logic [15:0]      cur_bits     = 16'd16;

  always #6 clk = ~clk;

  riff_wav_header_parser DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  wav_summary_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .fails      (fails),
    .outstanding(outstanding)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_riff_wav_header_parser: FAIL");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin : receiver
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  task automatic put8(input logic [7:0] v);
    wav_q = {wav_q, v};
  endtask

  task automatic put32(input logic [31:0] v);
    for (int i = 0; i < 4; i++) put8(v[8*i +: 8]);
  endtask

  task automatic put_header();
    put32(RIFF_TAG);
    put32($urandom);
    put32(WAVE_TAG);
  endtask

  task automatic put_blob(input logic [31:0] id, input logic [31:0] size);
    put32(id);
    put32(size);
    for (int i = 0; i < size; i++) put8(8'($urandom));
    if (size[0]) put8(8'($urandom));
    pad_at_end = size[0];
  endtask

  task automatic put_fmt(input logic [31:0] size, input logic [15:0] f, input logic [15:0] c,
                         input logic [31:0] r, input logic [15:0] b);
    logic [7:0] v;
    put32(FMT_TAG);
    put32(size);
    for (int i = 0; i < size; i++) begin
      case (i)
        0:       v = f[7:0];
        1:       v = f[15:8];
        2:       v = c[7:0];
        3:       v = c[15:8];
        4:       v = r[7:0];
        5:       v = r[15:8];
        6:       v = r[23:16];
        7:       v = r[31:24];
        14:      v = b[7:0];
        15:      v = b[15:8];
        default: v = 8'($urandom);
      endcase
      put8(v);
    end
    if (size[0]) put8(8'($urandom));
    pad_at_end = size[0];
  endtask

  task automatic put_good_fmt();
    put_fmt(32'd16, cur_format, cur_channels, cur_rate, cur_bits);
  endtask

  task automatic put_fmt_rand();
    int          pick;
    logic [31:0] sz;
    logic [15:0] f;
    logic [15:0] c;
    logic [31:0] r;
    logic [15:0] b;
    pick = $urandom_range(0, 9);
    if (pick < 6) sz = 32'd16;
    else if (pick < 9) sz = $urandom_range(17, 24);
    else sz = $urandom_range(0, 15);
    f = cur_format;
    c = cur_channels;
    r = cur_rate;
    b = cur_bits;
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 3))
        0:       f = 16'($urandom);
        1:       c = 16'($urandom);
        2:       r = $urandom;
        default: b = 16'($urandom);
      endcase
    end
    put_fmt(sz, f, c, r, b);
  endtask

  // a chunk that may declare far more than the file holds, which ends the file
  task automatic put_chunk_rand(input logic [31:0] id, output logic cut);
    cut = 1'b0;
    if ($urandom_range(0, 11) == 0) begin
      put32(id);
      put32($urandom | 32'h100);
      repeat ($urandom_range(0, 4)) put8(8'($urandom));
      cut = 1'b1;
    end else begin
      put_blob(id, $urandom_range(0, 9));
    end
  endtask

  task automatic gen_wellformed();
    int   fmt_slot;
    int   data_slot;
    logic cut;
    fmt_slot  = $urandom_range(0, 2);
    data_slot = $urandom_range(0, 3);
    if (data_slot == fmt_slot) data_slot = 3;
    if ($urandom_range(0, 9) == 0) fmt_slot = -1;
    if ($urandom_range(0, 9) == 0) data_slot = -1;
    cut = 1'b0;
    pad_at_end = 1'b0;
    put_header();
    for (int s = 0; s < 4 && !cut; s++) begin
      if (s == fmt_slot) put_fmt_rand();
      else if (s == data_slot) put_chunk_rand(DATA_TAG, cut);
      else if ($urandom_range(0, 3) == 0) put_chunk_rand(DATA_TAG, cut);
      else if ($urandom_range(0, 1) == 0) put_chunk_rand($urandom_range(0, 1) ? LIST_TAG : $urandom, cut);
    end
    if (!cut) begin
      if (pad_at_end && $urandom_range(0, 3) == 0) begin
        void'(wav_q.pop_back());
      end else if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 7)) put8(8'($urandom));
      end
    end
  endtask

  task automatic gen_random_file();
    int pick;
    int n;
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      gen_wellformed();
    end else if (pick == 7) begin
      if ($urandom_range(0, 1) == 0) put_header();
      repeat ($urandom_range(1, 30)) put8(8'($urandom));
    end else begin
      gen_wellformed();
      if ($urandom_range(0, 1) == 0) begin
        n = $urandom_range(0, wav_q.size() - 1);
        wav_q[n] = wav_q[n] ^ (8'h01 << $urandom_range(0, 7));
      end else begin
        n = $urandom_range(1, wav_q.size());
        while (wav_q.size() > n) void'(wav_q.pop_back());
      end
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic fin);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_file();
    case ($urandom_range(0, 2))
      0:       gap_odds = 0;
      1:       gap_odds = 2;
      default: gap_odds = 6;
    endcase
    if (calm) gap_odds = 0;
    for (int i = 0; i < wav_q.size(); i++) send_byte(wav_q[i], i == wav_q.size() - 1);
    wav_q.delete();
    files_sent++;
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] addr, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic load_config(input logic [15:0] f, input logic [15:0] c,
                             input logic [31:0] r, input logic [15:0] b);
    logic [15:0] junk;
    wait_idle();
    junk = 16'($urandom);
    write_reg(CFG_FORMAT, {junk, f});
    junk = 16'($urandom);
    write_reg(CFG_CHANNELS, {junk, c});
    write_reg(CFG_RATE, r);
    junk = 16'($urandom);
    write_reg(CFG_BITS, {junk, b});
    cfg_we <= 1'b0;
    @(posedge clk);
    cur_format   = f;
    cur_channels = c;
    cur_rate     = r;
    cur_bits     = b;
  endtask

  initial begin : stimulus
    int start_bytes;
    int start_files;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    put_header(); put_good_fmt(); put_blob(DATA_TAG, 4); send_file();
    put_header(); put_good_fmt(); put_blob(DATA_TAG, 3); send_file();
    put_header(); put_blob(DATA_TAG, 2); send_file();
    put_header(); put_fmt(14, cur_format, cur_channels, cur_rate, cur_bits);
    put_blob(DATA_TAG, 2); send_file();
    put_header(); put_fmt(16, 16'd3, 16'd2, 32'd44100, 16'd24); put_blob(DATA_TAG, 2);
    send_file();
    put8(8'h52); send_file();
    put32(RIFF_TAG); put8(8'h00); send_file();
    put_header(); wav_q[9] = 8'h58; put_blob(DATA_TAG, 2); send_file();
    put_header(); put_good_fmt(); put32(DATA_TAG); put32(32'hFFFF_FFFF);
    repeat (3) put8(8'($urandom)); send_file();
    // odd chunk with pad, long fmt, data overridden, trailing partial header
    put_header(); put_blob(LIST_TAG, 5); put_fmt(18, cur_format, cur_channels, cur_rate, cur_bits);
    put_blob(DATA_TAG, 6); put_blob(DATA_TAG, 2); repeat (5) put8(8'($urandom)); send_file();
    // odd data with the pad byte missing at the end
    put_header(); put_good_fmt(); put_blob(DATA_TAG, 5); void'(wav_q.pop_back()); send_file();
    put_header(); send_file();
    put_header(); put_fmt(0, 16'h0, 16'h0, 32'h0, 16'h0); put_blob(DATA_TAG, 2); send_file();
    put_header(); put32(FMT_TAG); put32(12); repeat (5) put8(8'($urandom)); send_file();
    put_header(); put_good_fmt(); put32(DATA_TAG); put32(4); send_file();
    repeat (20) put8(8'hFF); send_file();
    repeat (20) put8(8'h00); send_file();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1:       load_config(16'h0000, 16'h0000, 32'h0000_0000, 16'h0000);
        2:       load_config(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        3:       load_config(16'($urandom), 16'($urandom), $urandom, 16'($urandom));
        4:       load_config(16'd1, 16'd2, 32'd48000, 16'd24);
        default: ;
      endcase
      calm = (ph == 4);
      start_bytes = bytes_sent;
      start_files = files_sent;
      while (bytes_sent - start_bytes < PHASE_BYTES || files_sent - start_files < PHASE_FILES) begin
        if (ph == 0 && files_sent - start_files == 0) hold_req = 1'b1;
        gen_random_file();
        send_file();
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (fails == 0) begin
      $display("tb_riff_wav_header_parser: PASS");
    end else begin
      $display("tb_riff_wav_header_parser: FAIL");
    end
    $finish;
  end

endmodule

### riff_wav_header_parser.f
hw/rtl/rwp_pkg.sv
hw/rtl/rwp_front.sv
hw/rtl/rwp_queue.sv
hw/rtl/rwp_back.sv
hw/rtl/riff_wav_header_parser.sv
sim/wav_summary_checker.sv
sim/tb_riff_wav_header_parser.sv
